// ----- rtl/pez_pkg.sv -----
`default_nettype none

package pez_pkg;

    localparam int POS_W    = 14;
    localparam int PACK_W   = 2 * POS_W;
    localparam int SQ_W     = 2 * POS_W;
    localparam int LIMIT_W  = 24;
    localparam int RADIUS_W = 8;
    localparam int MAXSPK_W = 5;
    localparam int SLOT_W   = 4;
    localparam int KIND_W   = 2;
    localparam int VERD_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 8'd8;
    localparam logic [MAXSPK_W-1:0] MAXSPK_RST = 5'd16;
    localparam logic                CHECK_RST  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_CAND  = 2'd2
    } kind_t;

    typedef enum logic [VERD_W-1:0] {
        VERDICT_KEPT        = 2'd0,
        VERDICT_NEAR_ACTIVE = 2'd1,
        VERDICT_NEAR_KEPT   = 2'd2,
        VERDICT_CAP         = 2'd3
    } verdict_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_MAXSPK = 2'd1,
        CFG_CHECK  = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIMIT,
        ST_A_RD,
        ST_A_SQX,
        ST_A_SQY,
        ST_K_RD,
        ST_K_SQX,
        ST_K_SQY,
        ST_DECIDE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        DOP_NONE,
        DOP_LIMIT,
        DOP_SQX,
        DOP_SQY
    } dist_op_t;

    typedef struct packed {
        dist_op_t            op;
        logic [RADIUS_W-1:0] radius;
        logic [POS_W-1:0]    cand_x;
        logic [POS_W-1:0]    cand_y;
    } dist_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/pez_ifs.sv -----
`default_nettype none

interface pez_item_if;
    logic                      valid;
    logic                      ready;
    logic [pez_pkg::KIND_W-1:0] kind;
    logic [pez_pkg::POS_W-1:0]  x_pos;
    logic [pez_pkg::POS_W-1:0]  y_pos;

    modport source (output valid, kind, x_pos, y_pos, input ready);
    modport sink   (input valid, kind, x_pos, y_pos, output ready);
endinterface

interface pez_result_if;
    logic                       valid;
    logic                       ready;
    logic                       accepted;
    logic [pez_pkg::SLOT_W-1:0] slot;
    logic [pez_pkg::VERD_W-1:0] verdict;

    modport source (output valid, accepted, slot, verdict, input ready);
    modport sink   (input valid, accepted, slot, verdict, output ready);
endinterface

interface pez_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pez_pkg::CFG_IDX_W-1:0]  index;
    logic [pez_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/pez_ram.sv -----
`default_nettype none

module pez_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [ADDR_W-1:0]       waddr,
    input  wire logic [WIDTH-1:0]        wdata,
    input  wire logic                    re,
    input  wire logic [ADDR_W-1:0]       raddr,
    output logic      [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pez_dist_unit.sv -----
`default_nettype none

// One squarer, shared between the radius limit, dx and dy.
module pez_dist_unit (
    input  wire logic                             clk,
    input  wire pez_pkg::dist_ctl_t               ctl,
    input  wire logic [pez_pkg::PACK_W-1:0]       stored,
    output logic                                  near
);

    logic [pez_pkg::POS_W-1:0]   px;
    logic [pez_pkg::POS_W-1:0]   py;
    logic [pez_pkg::POS_W-1:0]   dx;
    logic [pez_pkg::POS_W-1:0]   dy;
    logic [pez_pkg::POS_W-1:0]   operand;
    logic [pez_pkg::SQ_W-1:0]    square;
    logic [pez_pkg::SQ_W:0]      dist_sum;
    logic [pez_pkg::LIMIT_W-1:0] limit_reg;
    logic [pez_pkg::LIMIT_W-1:0] limit_next;
    logic [pez_pkg::SQ_W-1:0]    sqx_reg;
    logic [pez_pkg::SQ_W-1:0]    sqx_next;

    assign px = stored[pez_pkg::POS_W-1:0];
    assign py = stored[pez_pkg::PACK_W-1:pez_pkg::POS_W];
    assign dx = (px > ctl.cand_x) ? (px - ctl.cand_x) : (ctl.cand_x - px);
    assign dy = (py > ctl.cand_y) ? (py - ctl.cand_y) : (ctl.cand_y - py);

    always_comb
    begin
        unique case (ctl.op)
            pez_pkg::DOP_LIMIT: operand = {2'b00, ctl.radius, 4'b0000};
            pez_pkg::DOP_SQX:   operand = dx;
            pez_pkg::DOP_SQY:   operand = dy;
            default:            operand = '0;
        endcase
    end

    assign square   = operand * operand;
    assign dist_sum = {1'b0, sqx_reg} + {1'b0, square};
    assign near     = (ctl.op == pez_pkg::DOP_SQY) &&
                      (dist_sum <= (pez_pkg::SQ_W + 1)'(limit_reg));

    assign limit_next = (ctl.op == pez_pkg::DOP_LIMIT) ? square[pez_pkg::LIMIT_W-1:0]
                                                       : limit_reg;
    assign sqx_next   = (ctl.op == pez_pkg::DOP_SQX) ? square : sqx_reg;

    always_ff @(posedge clk)
    begin
        limit_reg <= limit_next;
        sqx_reg   <= sqx_next;
    end

endmodule

`default_nettype wire

// ----- rtl/peak_exclusion_zone_selector_unit.sv -----
// Start-frame and load beats leave the unit idle, so ready stays high for them.
// A candidate beat holds ready low while its active and kept entries are tested;
// its result is valid from the edge that raises ready.
// Each stored position passes a read, a dx and a dy state, the last two on one shared squarer;
// a near hit skips the decision state, and a result not yet taken stalls the done state.
// Reset clears both totals and loads the registers with 8, 16 and 1; stores are not cleared.
`default_nettype none

module peak_exclusion_zone_selector_unit #(
    parameter int ACTIVE_DEPTH = 16,
    parameter int KEPT_DEPTH   = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pez_item_if.sink      item,
    pez_result_if.source  result,
    pez_cfg_if.sink       cfg
);

    localparam int ATW   = $clog2(ACTIVE_DEPTH + 1);
    localparam int KTW   = $clog2(KEPT_DEPTH + 1);
    localparam int AAW   = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
    localparam int KAW   = (KEPT_DEPTH > 1) ? $clog2(KEPT_DEPTH) : 1;
    localparam int IW    = (ATW > KTW) ? ATW : KTW;
    localparam int SLW   = (KTW > pez_pkg::SLOT_W) ? KTW : pez_pkg::SLOT_W;
    localparam int CAP_W0 = (ATW > KTW) ? ATW : KTW;
    localparam int CAP_W = (CAP_W0 > pez_pkg::MAXSPK_W) ? CAP_W0 : pez_pkg::MAXSPK_W;

    pez_pkg::state_t state_reg;
    pez_pkg::state_t state_next;

    logic [IW-1:0]                 idx_reg;
    logic [IW-1:0]                 idx_next;
    logic [IW-1:0]                 idx_inc;
    logic [ATW-1:0]                active_total_reg;
    logic [ATW-1:0]                active_total_next;
    logic [KTW-1:0]                kept_total_reg;
    logic [KTW-1:0]                kept_total_next;
    logic [pez_pkg::RADIUS_W-1:0]  radius_reg;
    logic [pez_pkg::MAXSPK_W-1:0]  max_spk_reg;
    logic                          check_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    logic [pez_pkg::POS_W-1:0]     cand_x_reg;
    logic [pez_pkg::POS_W-1:0]     cand_y_reg;
    pez_pkg::verdict_t             verdict_reg;
    pez_pkg::verdict_t             verdict_next;
    logic [pez_pkg::SLOT_W-1:0]    slot_reg;
    logic [pez_pkg::SLOT_W-1:0]    slot_next;
    logic                          out_accepted_reg;
    logic [pez_pkg::SLOT_W-1:0]    out_slot_reg;
    pez_pkg::verdict_t             out_verdict_reg;
    logic                          load_out;

    logic                          item_acc;
    pez_pkg::kind_t                item_kind;
    logic                          act_we;
    logic                          kept_we;
    logic [pez_pkg::PACK_W-1:0]    act_rdata;
    logic [pez_pkg::PACK_W-1:0]    kept_rdata;
    logic [pez_pkg::PACK_W-1:0]    stored;
    pez_pkg::dist_ctl_t            dctl;
    logic                          near;

    logic [SLW-1:0]                kept_ext;
    logic [CAP_W-1:0]              ms_ext;
    logic [CAP_W-1:0]              at_ext;
    logic [CAP_W-1:0]              cap_a;
    logic [CAP_W-1:0]              cap;
    logic                          cap_full;

    assign item.ready = (state_reg == pez_pkg::ST_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign item_kind  = pez_pkg::kind_t'(item.kind);
    assign cfg.ready  = 1'b1;

    assign idx_inc  = idx_reg + 1'b1;
    assign kept_ext = SLW'(kept_total_reg);

    assign ms_ext   = CAP_W'(max_spk_reg);
    assign at_ext   = check_reg ? CAP_W'(active_total_reg) : '0;
    assign cap_a    = (ms_ext > at_ext) ? (ms_ext - at_ext) : '0;
    assign cap      = (cap_a > CAP_W'(KEPT_DEPTH)) ? CAP_W'(KEPT_DEPTH) : cap_a;
    assign cap_full = (CAP_W'(kept_total_reg) >= cap);

    assign act_we  = item_acc && (item_kind == pez_pkg::KIND_LOAD) &&
                     (active_total_reg < ATW'(ACTIVE_DEPTH));
    assign kept_we = (state_reg == pez_pkg::ST_DECIDE) && !cap_full;

    pez_ram #(
        .WIDTH (pez_pkg::PACK_W),
        .DEPTH (ACTIVE_DEPTH)
    ) u_active_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (active_total_reg[AAW-1:0]),
        .wdata ({item.y_pos, item.x_pos}),
        .re    (state_reg == pez_pkg::ST_A_RD),
        .raddr (idx_reg[AAW-1:0]),
        .rdata (act_rdata)
    );

    pez_ram #(
        .WIDTH (pez_pkg::PACK_W),
        .DEPTH (KEPT_DEPTH)
    ) u_kept_ram (
        .clk   (clk),
        .we    (kept_we),
        .waddr (kept_total_reg[KAW-1:0]),
        .wdata ({cand_y_reg, cand_x_reg}),
        .re    (state_reg == pez_pkg::ST_K_RD),
        .raddr (idx_reg[KAW-1:0]),
        .rdata (kept_rdata)
    );

    assign stored = ((state_reg == pez_pkg::ST_A_SQX) || (state_reg == pez_pkg::ST_A_SQY))
                    ? act_rdata : kept_rdata;

    always_comb
    begin
        dctl.radius = radius_reg;
        dctl.cand_x = cand_x_reg;
        dctl.cand_y = cand_y_reg;
        unique case (state_reg)
            pez_pkg::ST_LIMIT:                     dctl.op = pez_pkg::DOP_LIMIT;
            pez_pkg::ST_A_SQX, pez_pkg::ST_K_SQX:  dctl.op = pez_pkg::DOP_SQX;
            pez_pkg::ST_A_SQY, pez_pkg::ST_K_SQY:  dctl.op = pez_pkg::DOP_SQY;
            default:                               dctl.op = pez_pkg::DOP_NONE;
        endcase
    end

    pez_dist_unit u_dist (
        .clk    (clk),
        .ctl    (dctl),
        .stored (stored),
        .near   (near)
    );

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        active_total_next = active_total_reg;
        kept_total_next   = kept_total_reg;
        verdict_next      = verdict_reg;
        slot_next         = slot_reg;
        load_out          = 1'b0;
        out_valid_next    = out_valid_reg && !result.ready;

        unique case (state_reg)
            pez_pkg::ST_IDLE:
            begin
                if (item_acc)
                begin
                    unique case (item_kind)
                        pez_pkg::KIND_START:
                        begin
                            active_total_next = '0;
                            kept_total_next   = '0;
                        end
                        pez_pkg::KIND_LOAD:
                        begin
                            if (act_we)
                            begin
                                active_total_next = active_total_reg + 1'b1;
                            end
                        end
                        pez_pkg::KIND_CAND:
                        begin
                            state_next = pez_pkg::ST_LIMIT;
                        end
                        default:
                        begin
                            state_next = pez_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            pez_pkg::ST_LIMIT:
            begin
                idx_next     = '0;
                verdict_next = pez_pkg::VERDICT_KEPT;
                slot_next    = '0;
                if (check_reg && (active_total_reg != '0))
                begin
                    state_next = pez_pkg::ST_A_RD;
                end
                else if (kept_total_reg != '0)
                begin
                    state_next = pez_pkg::ST_K_RD;
                end
                else
                begin
                    state_next = pez_pkg::ST_DECIDE;
                end
            end
            pez_pkg::ST_A_RD:
            begin
                state_next = pez_pkg::ST_A_SQX;
            end
            pez_pkg::ST_A_SQX:
            begin
                state_next = pez_pkg::ST_A_SQY;
            end
            pez_pkg::ST_A_SQY:
            begin
                idx_next = idx_inc;
                if (near)
                begin
                    verdict_next = pez_pkg::VERDICT_NEAR_ACTIVE;
                    state_next   = pez_pkg::ST_DONE;
                end
                else if (idx_inc != IW'(active_total_reg))
                begin
                    state_next = pez_pkg::ST_A_RD;
                end
                else if (kept_total_reg != '0)
                begin
                    idx_next   = '0;
                    state_next = pez_pkg::ST_K_RD;
                end
                else
                begin
                    state_next = pez_pkg::ST_DECIDE;
                end
            end
            pez_pkg::ST_K_RD:
            begin
                state_next = pez_pkg::ST_K_SQX;
            end
            pez_pkg::ST_K_SQX:
            begin
                state_next = pez_pkg::ST_K_SQY;
            end
            pez_pkg::ST_K_SQY:
            begin
                idx_next = idx_inc;
                if (near)
                begin
                    verdict_next = pez_pkg::VERDICT_NEAR_KEPT;
                    state_next   = pez_pkg::ST_DONE;
                end
                else if (idx_inc != IW'(kept_total_reg))
                begin
                    state_next = pez_pkg::ST_K_RD;
                end
                else
                begin
                    state_next = pez_pkg::ST_DECIDE;
                end
            end
            pez_pkg::ST_DECIDE:
            begin
                state_next = pez_pkg::ST_DONE;
                if (cap_full)
                begin
                    verdict_next = pez_pkg::VERDICT_CAP;
                end
                else
                begin
                    slot_next       = kept_ext[pez_pkg::SLOT_W-1:0];
                    kept_total_next = kept_total_reg + 1'b1;
                end
            end
            pez_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = pez_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pez_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pez_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg          <= '0;
            active_total_reg <= '0;
            kept_total_reg   <= '0;
            out_valid_reg    <= 1'b0;
            radius_reg       <= pez_pkg::RADIUS_RST;
            max_spk_reg      <= pez_pkg::MAXSPK_RST;
            check_reg        <= pez_pkg::CHECK_RST;
        end
        else
        begin
            idx_reg          <= idx_next;
            active_total_reg <= active_total_next;
            kept_total_reg   <= kept_total_next;
            out_valid_reg    <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (pez_pkg::cfg_idx_t'(cfg.index))
                    pez_pkg::CFG_RADIUS: radius_reg  <= cfg.data;
                    pez_pkg::CFG_MAXSPK: max_spk_reg <= cfg.data[pez_pkg::MAXSPK_W-1:0];
                    pez_pkg::CFG_CHECK:  check_reg   <= cfg.data[0];
                    default:             radius_reg  <= radius_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        slot_reg    <= slot_next;
        if (item_acc)
        begin
            cand_x_reg <= item.x_pos;
            cand_y_reg <= item.y_pos;
        end
        if (load_out)
        begin
            out_accepted_reg <= (verdict_reg == pez_pkg::VERDICT_KEPT);
            out_slot_reg     <= slot_reg;
            out_verdict_reg  <= verdict_reg;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.accepted = out_accepted_reg;
    assign result.slot     = out_slot_reg;
    assign result.verdict  = out_verdict_reg;

    // The totals never pass the depth of their stores.
    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_total_reg <= KTW'(KEPT_DEPTH))
        else $error("kept total beyond store depth");

    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_total_reg <= ATW'(ACTIVE_DEPTH))
        else $error("active total beyond store depth");

    // A kept beat carries the kept verdict; a rejected one carries slot zero.
    a_kept_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.accepted) |-> (result.verdict == pez_pkg::VERDICT_KEPT))
        else $error("kept beat with a rejecting verdict");

    a_reject_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.accepted) |->
        ((result.slot == '0) && (result.verdict != pez_pkg::VERDICT_KEPT)))
        else $error("rejected beat with a slot or kept verdict");

    // The kept total moves only on a decision or on a start of frame.
    a_kept_stable: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != pez_pkg::ST_DECIDE) && !item_acc) |=> $stable(kept_total_reg))
        else $error("kept total changed outside a decision");

endmodule

`default_nettype wire
